FILE: sv/assert_macros.svh
// Assertion macros used by the sharpener top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/lls_pkg.sv
// Shared types and constants of the luma Laplacian sharpener.
`default_nettype none

package lls_pkg;

   // configuration register widths and indexes
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int AMOUNT_REG_BITS = 10;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 13;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHARPEN_AMOUNT = 2'd2;

   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [AMOUNT_REG_BITS-1:0] AMOUNT_RESET = 10'd256;

   localparam int MAX_HEIGHT = 4096;
   localparam int ROW_BITS   = 12;
   localparam int PIXEL_BITS = 24;

   localparam logic [AMOUNT_REG_BITS-1:0] GAIN_MAX = 10'd512;

   // luma weights, Q.16, summing to 65536
   localparam logic [PIXEL_BITS-1:0] LUMA_RED   = 24'd13933;
   localparam logic [PIXEL_BITS-1:0] LUMA_GREEN = 24'd46871;
   localparam logic [PIXEL_BITS-1:0] LUMA_BLUE  = 24'd4732;

   localparam int QUEUE_DEPTH = 4;

   // position class of one pixel, set by the front end
   typedef struct packed {
      logic up_one;     // a row above exists
      logic up_two;     // two rows above exist
      logic left_ok;    // column at least 1
      logic left_two;   // column at least 2
      logic right_ok;   // a column to the right exists
      logic col_last;   // last column of the line
      logic last_row;   // last row of the frame
   } item_flags_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FETCH,
      BK_RIGHT,
      BK_LUMA,
      BK_GAIN,
      BK_CHAN
   } back_state_type;

endpackage

`default_nettype wire

FILE: sv/lls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lls_ram #(
   parameter int WIDTH     = 24,
   parameter int DEPTH     = 1024,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/lls_queue.sv
// Small register FIFO between the front end and the back end.
`default_nettype none

module lls_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_en,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop_en,
   output logic                  pop_valid,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] ptr_step(input logic [PW-1:0] ptr);
      return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push_en ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_en ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_en && !pop_en) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop_en && !push_en) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: sv/lls_front.sv
// Front end: accepts pixels, tracks the raster position and classifies it.
`default_nettype none

module lls_front import lls_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int ADDR_BITS = $clog2(MAX_WIDTH)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [WIDTH_REG_BITS-1:0]  cfg_width,
   input  wire logic [HEIGHT_REG_BITS-1:0] cfg_height,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [7:0]                 req_red_in,
   input  wire logic [7:0]                 req_green_in,
   input  wire logic [7:0]                 req_blue_in,
   input  wire logic                       q_full,
   output logic                            push_en,
   output logic      [PIXEL_BITS-1:0]      item_pixel,
   output logic      [ADDR_BITS-1:0]       item_x,
   output item_flags_type                  item_flags
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (WW > WIDTH_REG_BITS) ? WW : WIDTH_REG_BITS;

   logic [ADDR_BITS-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0]        row_ff, row_in;
   logic [CW-1:0]              cfg_w, w_eff, col_ext, x_ext, x_plus;
   logic [HEIGHT_REG_BITS-1:0] h_eff, y_pre, y_ext, y_plus;
   logic [ADDR_BITS-1:0]       x;
   logic [ROW_BITS-1:0]        y;

   always_comb begin
      cfg_w = CW'(cfg_width);
      if (cfg_w == '0) begin
         w_eff = CW'(1);
      end else if (cfg_w > CW'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = cfg_w;
      end

      if (cfg_height == '0) begin
         h_eff = HEIGHT_REG_BITS'(1);
      end else if (cfg_height > HEIGHT_REG_BITS'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_REG_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = cfg_height;
      end

      // a stale position past a narrowed line starts the next line
      col_ext = CW'(col_ff);
      if (col_ext >= w_eff) begin
         x     = '0;
         y_pre = HEIGHT_REG_BITS'(row_ff) + HEIGHT_REG_BITS'(1);
      end else begin
         x     = col_ff;
         y_pre = HEIGHT_REG_BITS'(row_ff);
      end
      y = (y_pre >= h_eff) ? '0 : y_pre[ROW_BITS-1:0];

      y_ext  = HEIGHT_REG_BITS'(y);
      y_plus = y_ext + HEIGHT_REG_BITS'(1);
      x_ext  = CW'(x);
      x_plus = x_ext + CW'(1);

      item_flags.up_one   = (y_ext != '0);
      item_flags.up_two   = (y_ext >= HEIGHT_REG_BITS'(2));
      item_flags.left_ok  = (x_ext != '0);
      item_flags.left_two = (x_ext >= CW'(2));
      item_flags.right_ok = (x_plus < w_eff);
      item_flags.col_last = (x_plus == w_eff);
      item_flags.last_row = (y_plus == h_eff);

      push_en = req_valid && !q_full;

      col_in = col_ff;
      row_in = row_ff;
      if (push_en) begin
         if (x_plus >= w_eff) begin
            col_in = '0;
            row_in = (y_plus >= h_eff) ? '0 : y_plus[ROW_BITS-1:0];
         end else begin
            col_in = x_plus[ADDR_BITS-1:0];
            row_in = y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign req_stall  = q_full;
   assign item_pixel = {req_red_in, req_green_in, req_blue_in};
   assign item_x     = x;

endmodule

`default_nettype wire

FILE: sv/lls_back.sv
// Back end: line buffers, edge accumulation, gain and the result register.
`default_nettype none

module lls_back import lls_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int ADDR_BITS = $clog2(MAX_WIDTH)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [AMOUNT_REG_BITS-1:0] cfg_amount,
   input  wire logic                       q_valid,
   output logic                            q_pop,
   input  wire logic [PIXEL_BITS-1:0]      q_pixel,
   input  wire logic [ADDR_BITS-1:0]       q_x,
   input  wire item_flags_type             q_flags,
   output logic                            back_idle,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [7:0]                 rsp_red_out,
   output logic      [7:0]                 rsp_green_out,
   output logic      [7:0]                 rsp_blue_out,
   output logic                            rsp_run_last,
   output logic                            rsp_frame_end
);

   localparam int EDGE_BITS = 27;
   localparam int PROD_BITS = 36;
   localparam int SUM_BITS  = 37;

   localparam logic [1:0] JOB_UP       = 2'd0;   // result for the row above
   localparam logic [1:0] JOB_LAST_ROW = 2'd1;   // last row, column to the left
   localparam logic [1:0] JOB_END      = 2'd2;   // last pixel of the frame

   localparam logic [2:0] TERM_CENTER = 3'd0;
   localparam logic [2:0] TERM_LEFT   = 3'd1;
   localparam logic [2:0] TERM_RIGHT  = 3'd2;
   localparam logic [2:0] TERM_UP     = 3'd3;
   localparam logic [2:0] TERM_LAST   = 3'd4;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] c;
      logic [PIXEL_BITS-1:0] l;
      logic [PIXEL_BITS-1:0] r;
      logic [PIXEL_BITS-1:0] u;
      logic [PIXEL_BITS-1:0] d;
   } window_type;

   back_state_type state_ff, state_in;

   logic [PIXEL_BITS-1:0] pix_ff, a_ff, b_ff;
   logic [PIXEL_BITS-1:0] rw0_ff, rw1_ff, d2_ff;
   logic [ADDR_BITS-1:0]  x_ff;
   item_flags_type        flags_ff;
   logic [1:0]            job_ff;
   window_type            win_ff, win_in;
   logic [2:0]            term_ff;
   logic signed [EDGE_BITS-1:0] acc_ff, acc_in, term_luma;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] red_ff, green_ff, blue_ff;
   logic       run_last_ff, frame_end_ff;

   logic [ADDR_BITS-1:0]  l1_rd_addr;
   logic [PIXEL_BITS-1:0] l1_rdata, l2_rdata;
   logic                  l1_we, l2_we;

   logic [2:0]            job_vld;
   logic                  any_job, has_next, out_free, out_load, win_load, item_done;
   logic [1:0]            first_job, next_job, job_sel;
   logic [PIXEL_BITS-1:0] term_px;
   logic [AMOUNT_REG_BITS-1:0] gain;

   function automatic logic [PIXEL_BITS-1:0] luma_q16(input logic [PIXEL_BITS-1:0] px);
      return ({16'd0, px[23:16]} * LUMA_RED) + ({16'd0, px[15:8]} * LUMA_GREEN)
           + ({16'd0, px[7:0]} * LUMA_BLUE);
   endfunction

   function automatic window_type build_window(
      input logic [1:0]            job,
      input logic [PIXEL_BITS-1:0] p,
      input logic [PIXEL_BITS-1:0] a,
      input logic [PIXEL_BITS-1:0] b,
      input logic [PIXEL_BITS-1:0] right_px,
      input logic [PIXEL_BITS-1:0] rw0,
      input logic [PIXEL_BITS-1:0] rw1,
      input logic [PIXEL_BITS-1:0] d2,
      input item_flags_type        f
   );
      window_type w;
      case (job)
         JOB_UP: begin
            w.c = a;
            w.l = f.left_ok  ? rw0 : a;
            w.r = f.right_ok ? right_px : a;
            w.u = f.up_two   ? b : a;
            w.d = p;
         end
         JOB_LAST_ROW: begin
            w.c = rw1;
            w.l = f.left_two ? d2 : rw1;
            w.r = p;
            w.u = f.up_one   ? rw0 : rw1;
            w.d = rw1;
         end
         default: begin
            w.c = p;
            w.l = f.left_ok ? rw1 : p;
            w.r = p;
            w.u = f.up_one  ? a : p;
            w.d = p;
         end
      endcase
      return w;
   endfunction

   // ch * 2^26 + gain * edge, rounded half away from zero, clamped to 0..255
   function automatic logic [7:0] sharpen(input logic [7:0] ch,
                                          input logic signed [PROD_BITS-1:0] prod);
      logic signed [SUM_BITS-1:0] v;
      logic [SUM_BITS-1:0]        rnd;
      logic [10:0]                q;
      v   = $signed({3'b000, ch, 26'd0}) + SUM_BITS'(prod);
      rnd = unsigned'(v) + (SUM_BITS'(1) << 25);
      q   = rnd[SUM_BITS-1:26];
      if (v[SUM_BITS-1]) begin
         return 8'd0;
      end else if (q > 11'd255) begin
         return 8'd255;
      end else begin
         return q[7:0];
      end
   endfunction

   lls_ram #(
      .WIDTH     (PIXEL_BITS),
      .DEPTH     (MAX_WIDTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_line_one (
      .clock   (clock),
      .wr_en   (l1_we),
      .wr_addr (x_ff),
      .wr_data (pix_ff),
      .rd_addr (l1_rd_addr),
      .rd_data (l1_rdata)
   );

   lls_ram #(
      .WIDTH     (PIXEL_BITS),
      .DEPTH     (MAX_WIDTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_line_two (
      .clock   (clock),
      .wr_en   (l2_we),
      .wr_addr (x_ff),
      .wr_data (l1_rdata),
      .rd_addr (q_x),
      .rd_data (l2_rdata)
   );

   // job selection
   always_comb begin
      job_vld[JOB_UP]       = flags_ff.up_one;
      job_vld[JOB_LAST_ROW] = flags_ff.last_row && flags_ff.left_ok;
      job_vld[JOB_END]      = flags_ff.last_row && flags_ff.col_last;
      any_job = |job_vld;
      if (job_vld[JOB_UP]) begin
         first_job = JOB_UP;
      end else if (job_vld[JOB_LAST_ROW]) begin
         first_job = JOB_LAST_ROW;
      end else begin
         first_job = JOB_END;
      end
      case (job_ff)
         JOB_UP: begin
            has_next = job_vld[JOB_LAST_ROW] || job_vld[JOB_END];
            next_job = job_vld[JOB_LAST_ROW] ? JOB_LAST_ROW : JOB_END;
         end
         JOB_LAST_ROW: begin
            has_next = job_vld[JOB_END];
            next_job = JOB_END;
         end
         default: begin
            has_next = 1'b0;
            next_job = JOB_END;
         end
      endcase
   end

   // datapath
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      out_load = (state_ff == BK_CHAN) && out_free;
      job_sel  = (state_ff == BK_RIGHT) ? first_job : next_job;
      win_in   = build_window(job_sel, pix_ff, a_ff, b_ff, l1_rdata,
                              rw0_ff, rw1_ff, d2_ff, flags_ff);

      case (term_ff)
         TERM_CENTER: term_px = win_ff.c;
         TERM_LEFT:   term_px = win_ff.l;
         TERM_RIGHT:  term_px = win_ff.r;
         TERM_UP:     term_px = win_ff.u;
         default:     term_px = win_ff.d;
      endcase
      term_luma = $signed({3'b000, luma_q16(term_px)});
      acc_in    = (term_ff == TERM_CENTER) ? (term_luma <<< 2) : (acc_ff - term_luma);

      gain    = (cfg_amount > GAIN_MAX) ? GAIN_MAX : cfg_amount;
      prod_in = PROD_BITS'($signed({1'b0, gain})) * PROD_BITS'(acc_ff);

      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (q_valid) state_in = BK_FETCH;
         BK_FETCH: state_in = BK_RIGHT;
         BK_RIGHT: state_in = any_job ? BK_LUMA : BK_IDLE;
         BK_LUMA:  if (term_ff == TERM_LAST) state_in = BK_GAIN;
         BK_GAIN:  state_in = BK_CHAN;
         BK_CHAN: begin
            if (out_load) begin
               state_in = has_next ? BK_LUMA : BK_IDLE;
            end
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop      = 1'b0;
      l1_we      = 1'b0;
      l2_we      = 1'b0;
      l1_rd_addr = x_ff + ADDR_BITS'(1);
      win_load   = 1'b0;
      item_done  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            q_pop      = q_valid;
            l1_rd_addr = q_x;
         end
         BK_FETCH: begin
            l2_we = 1'b1;   // row above moves down one buffer
         end
         BK_RIGHT: begin
            l1_we     = 1'b1;
            win_load  = any_job;
            item_done = !any_job;
         end
         BK_CHAN: begin
            win_load  = out_load && has_next;
            item_done = out_load && !has_next;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         rw0_ff       <= '0;
         rw1_ff       <= '0;
         d2_ff        <= '0;
         job_ff       <= JOB_UP;
         term_ff      <= TERM_CENTER;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (item_done) begin
            rw0_ff <= a_ff;
            rw1_ff <= pix_ff;
            d2_ff  <= rw1_ff;
         end
         if (win_load) begin
            job_ff  <= job_sel;
            term_ff <= TERM_CENTER;
         end else if (state_ff == BK_LUMA) begin
            term_ff <= term_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         pix_ff   <= q_pixel;
         x_ff     <= q_x;
         flags_ff <= q_flags;
      end
      if (state_ff == BK_FETCH) begin
         a_ff <= l1_rdata;
         b_ff <= l2_rdata;
      end
      if (win_load) begin
         win_ff <= win_in;
      end
      if (state_ff == BK_LUMA) begin
         acc_ff <= acc_in;
      end
      if (state_ff == BK_GAIN) begin
         prod_ff <= prod_in;
      end
      if (out_load) begin
         red_ff       <= sharpen(win_ff.c[23:16], prod_ff);
         green_ff     <= sharpen(win_ff.c[15:8], prod_ff);
         blue_ff      <= sharpen(win_ff.c[7:0], prod_ff);
         run_last_ff  <= !has_next;
         frame_end_ff <= (job_ff == JOB_END);
      end
   end

   assign back_idle     = (state_ff == BK_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

`default_nettype wire

FILE: sv/luma_laplacian_sharpen_stream_unit.sv
// Top level of the streaming luma Laplacian sharpener.
`default_nettype none

// Takes RGB pixels in raster order and returns each pixel sharpened by its
// luma Laplacian over the 3x3 cross (borders clamped), scaled by the Q2.8
// sharpen amount. Results trail the input by one line: input pixel (x,y)
// releases result (x,y-1), and the last row of the frame is flushed while it
// arrives, so a pixel causes zero to three results; run_last marks the last
// result of an input and frame_end the bottom right pixel. The front end
// takes a pixel whenever its four-entry queue has room. The back end pops a
// pixel in idle, reads and writes the two line-buffer RAMs through its fetch
// and right states, then for each result accumulates the edge in the single
// luma unit over the centre, left, right, up and down terms, does the gain
// multiply and loads the result register, which can stall; it takes the next
// pixel only once back in idle. The line buffers are not cleared at reset and
// need no clearing pass; configuration must be written between frames while
// the block is idle, which the block itself does not enforce.
module luma_laplacian_sharpen_stream_unit import lls_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_red_in,
   input  wire logic [7:0]                req_green_in,
   input  wire logic [7:0]                req_blue_in,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic      [7:0]                rsp_red_out,
   output logic      [7:0]                rsp_green_out,
   output logic      [7:0]                rsp_blue_out,
   output logic                           rsp_run_last,
   output logic                           rsp_frame_end,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

`include "assert_macros.svh"

   localparam int ADDR_BITS = $clog2(MAX_WIDTH);
   localparam int FLAG_BITS = $bits(item_flags_type);
   localparam int ITEM_BITS = FLAG_BITS + ADDR_BITS + PIXEL_BITS;

   logic [WIDTH_REG_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_BITS-1:0] height_ff, height_in;
   logic [AMOUNT_REG_BITS-1:0] amount_ff, amount_in;

   logic                  push_en, q_full, q_pop, q_pop_valid, back_idle;
   logic [PIXEL_BITS-1:0] item_pixel;
   logic [ADDR_BITS-1:0]  item_x;
   item_flags_type        item_flags;
   logic [ITEM_BITS-1:0]  push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      amount_in = amount_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    width_in  = csr_data[WIDTH_REG_BITS-1:0];
            CSR_IMAGE_HEIGHT:   height_in = csr_data[HEIGHT_REG_BITS-1:0];
            CSR_SHARPEN_AMOUNT: amount_in = csr_data[AMOUNT_REG_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         amount_ff <= AMOUNT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         amount_ff <= amount_in;
      end
   end

   lls_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg_width    (width_ff),
      .cfg_height   (height_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .q_full       (q_full),
      .push_en      (push_en),
      .item_pixel   (item_pixel),
      .item_x       (item_x),
      .item_flags   (item_flags)
   );

   assign push_data = {item_flags, item_x, item_pixel};

   lls_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (push_data),
      .full      (q_full),
      .pop_en    (q_pop),
      .pop_valid (q_pop_valid),
      .pop_data  (pop_data)
   );

   lls_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg_amount    (amount_ff),
      .q_valid       (q_pop_valid),
      .q_pop         (q_pop),
      .q_pixel       (pop_data[PIXEL_BITS-1:0]),
      .q_x           (pop_data[PIXEL_BITS+ADDR_BITS-1:PIXEL_BITS]),
      .q_flags       (pop_data[ITEM_BITS-1:PIXEL_BITS+ADDR_BITS]),
      .back_idle     (back_idle),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

   // the frame's last result always closes the run of its input pixel
   `ASSERT_IMPLIES(a_frame_end_is_last, clock, reset, rsp_valid && rsp_frame_end, rsp_run_last, "frame_end without run_last")
   // a queued pixel is taken up by the back end without delay
   `ASSERT_NEXT(a_queue_drains, clock, reset, q_pop_valid && back_idle, !back_idle, "back end idle with queued pixel")
   // a pop only ever happens on a non-empty queue, with the back end idle
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, q_pop, q_pop_valid && back_idle, "pop from empty queue or busy back end")

endmodule

`default_nettype wire

FILE: verif/tb_luma_laplacian_sharpen_stream_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming luma Laplacian sharpener.
module tb_luma_laplacian_sharpen_stream_unit;
   import lls_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int SETTLE_CYCLES = 120;
   localparam int IDLE_PERCENT  = 24;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       run_last;
      logic       frame_end;
   } sharp_pixel_type;

   typedef enum {PIX_RANDOM, PIX_EXTREME} pix_mode_type;

   class sharpen_scoreboard;
      logic [WIDTH_REG_BITS-1:0]  width_reg;
      logic [HEIGHT_REG_BITS-1:0] height_reg;
      logic [AMOUNT_REG_BITS-1:0] amount_reg;
      logic [PIXEL_BITS-1:0]      line_one[MAX_WIDTH];
      logic [PIXEL_BITS-1:0]      line_two[MAX_WIDTH];
      logic [PIXEL_BITS-1:0]      prev_up;
      logic [PIXEL_BITS-1:0]      prev_cur;
      int unsigned                col;
      int unsigned                row;
      sharp_pixel_type            sharpened_q[$];
      int                         errors;

      function new();
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         amount_reg = AMOUNT_RESET;
         foreach (line_one[i]) begin
            line_one[i] = '0;
            line_two[i] = '0;
         end
         prev_up  = '0;
         prev_cur = '0;
         col      = 0;
         row      = 0;
         errors   = 0;
      endfunction

      function int unsigned eff_width();
         int unsigned w;
         w = 32'(width_reg);
         if (w == 0) w = 1;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         return w;
      endfunction

      function int unsigned eff_height();
         int unsigned h;
         h = 32'(height_reg);
         if (h == 0) h = 1;
         if (h > MAX_HEIGHT) h = MAX_HEIGHT;
         return h;
      endfunction

      function int pending();
         return sharpened_q.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_IMAGE_WIDTH:    width_reg  = data[WIDTH_REG_BITS-1:0];
            CSR_IMAGE_HEIGHT:   height_reg = data[HEIGHT_REG_BITS-1:0];
            CSR_SHARPEN_AMOUNT: amount_reg = data[AMOUNT_REG_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Q.16 luma
      function longint luma(logic [PIXEL_BITS-1:0] p);
         return longint'(LUMA_RED) * longint'(p[23:16]) +
                longint'(LUMA_GREEN) * longint'(p[15:8]) +
                longint'(LUMA_BLUE) * longint'(p[7:0]);
      endfunction

      function logic [7:0] sharpen_chan(logic [7:0] level, longint edge_q18, longint gain);
         longint v;
         v = (longint'(level) <<< 26) + gain * edge_q18;
         if (v < 0) return 8'd0;
         v = (v + (longint'(1) <<< 25)) >>> 26;
         if (v > 255) return 8'd255;
         return v[7:0];
      endfunction

      function sharp_pixel_type sharpen(logic [PIXEL_BITS-1:0] c, logic [PIXEL_BITS-1:0] l,
                                        logic [PIXEL_BITS-1:0] r, logic [PIXEL_BITS-1:0] u,
                                        logic [PIXEL_BITS-1:0] d, logic last_px);
         sharp_pixel_type res;
         longint          edge_q18;
         longint          gain;
         gain = (amount_reg > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(amount_reg);
         edge_q18 = 4 * luma(c) - (luma(l) + luma(r) + luma(u) + luma(d));
         res.red       = sharpen_chan(c[23:16], edge_q18, gain);
         res.green     = sharpen_chan(c[15:8], edge_q18, gain);
         res.blue      = sharpen_chan(c[7:0], edge_q18, gain);
         res.run_last  = 1'b0;
         res.frame_end = last_px;
         return res;
      endfunction

      // One accepted input pixel: releases the pixel above it, plus the flush of the last row.
      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         int unsigned           w, h, x, y;
         logic [PIXEL_BITS-1:0] p, above, above2, left, right, up, c;
         sharp_pixel_type       batch[$];
         w = eff_width();
         h = eff_height();
         if (col >= w) begin
            col = 0;
            row++;
         end
         if (row >= h) row = 0;
         x = col;
         y = row;
         p      = {r, g, b};
         above  = line_one[x];
         above2 = line_two[x];
         if (y >= 1) begin
            left  = (x > 0) ? prev_up : above;
            right = (x + 1 < w) ? line_one[x + 1] : above;
            up    = (y >= 2) ? above2 : above;
            batch.push_back(sharpen(above, left, right, up, p, 1'b0));
         end
         line_two[x] = above;
         line_one[x] = p;
         prev_up     = above;
         if (y == h - 1 && x >= 1) begin
            c    = prev_cur;
            left = (x >= 2) ? line_one[x - 2] : c;
            up   = (y >= 1) ? line_two[x - 1] : c;
            batch.push_back(sharpen(c, left, p, up, c, 1'b0));
         end
         if (y == h - 1 && x == w - 1) begin
            left = (x >= 1) ? prev_cur : p;
            up   = (y >= 1) ? above : p;
            batch.push_back(sharpen(p, left, p, up, p, 1'b1));
         end
         prev_cur = p;
         if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
         foreach (batch[i]) sharpened_q.push_back(batch[i]);
         col = x + 1;
         if (col >= w) begin
            col = 0;
            row = y + 1;
            if (row >= h) row = 0;
         end
      endfunction

      function void check_result(sharp_pixel_type got);
         sharp_pixel_type want;
         if (sharpened_q.size() == 0) begin
            $error("result with none expected: rgb %0d %0d %0d", got.red, got.green, got.blue);
            errors++;
            return;
         end
         want = sharpened_q.pop_front();
         if (got.red !== want.red) begin
            $error("red_out expected %0d actual %0d", want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $error("green_out expected %0d actual %0d", want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $error("blue_out expected %0d actual %0d", want.blue, got.blue);
            errors++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last expected %0d actual %0d", want.run_last, got.run_last);
            errors++;
         end
         if (got.frame_end !== want.frame_end) begin
            $error("frame_end expected %0d actual %0d", want.frame_end, got.frame_end);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_red_in = '0;
   logic [7:0]                req_green_in = '0;
   logic [7:0]                req_blue_in = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [7:0]                rsp_red_out;
   logic [7:0]                rsp_green_out;
   logic [7:0]                rsp_blue_out;
   logic                      rsp_run_last;
   logic                      rsp_frame_end;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;
   logic                      steady = 1'b0;

   sharpen_scoreboard board;
   int unsigned       random_pixels;

   luma_laplacian_sharpen_stream_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: check each transfer, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_red_out, rsp_green_out, rsp_blue_out,
                             rsp_run_last, rsp_frame_end});
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
   end

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      do @(posedge clock); while (req_stall);
      board.note_pixel(r, g, b);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
   endtask

   task automatic wait_idle();
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_frame(logic [CSR_DATA_BITS-1:0] w_reg, logic [CSR_DATA_BITS-1:0] h_reg,
                            logic [CSR_DATA_BITS-1:0] amt_reg, pix_mode_type mode, bit calm);
      int unsigned count;
      logic [7:0]  r, g, b;
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, w_reg);
      write_csr(CSR_IMAGE_HEIGHT, h_reg);
      write_csr(CSR_SHARPEN_AMOUNT, amt_reg);
      csr_valid <= 1'b0;
      steady    <= calm;
      count = board.eff_width() * board.eff_height();
      for (int unsigned i = 0; i < count; i++) begin
         r = 8'($urandom_range(255));
         g = 8'($urandom_range(255));
         b = 8'($urandom_range(255));
         if (mode == PIX_EXTREME) begin
            case (i % 6)
               0: {r, g, b} = {8'd0, 8'd0, 8'd0};
               1: {r, g, b} = {8'd255, 8'd255, 8'd255};
               2: {r, g, b} = {8'd255, 8'd0, 8'd0};
               3: {r, g, b} = {8'd0, 8'd255, 8'd0};
               4: {r, g, b} = {8'd0, 8'd0, 8'd255};
               default: ;
            endcase
         end else if ($urandom_range(3) == 0) begin
            // saturated channels drive the clamps
            r = $urandom_range(1) ? 8'd255 : 8'd0;
            g = $urandom_range(1) ? 8'd255 : 8'd0;
            b = $urandom_range(1) ? 8'd255 : 8'd0;
         end
         send_pixel(r, g, b);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      int unsigned w, h;
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_csr(CSR_UNUSED, 13'h1FFF);
      csr_valid <= 1'b0;

      // small shapes, border clamping, gain extremes, zero-sized register values
      run_frame(13'd4, 13'd3, 13'd256, PIX_EXTREME, 1'b0);
      run_frame(13'd1, 13'd1, 13'd512, PIX_EXTREME, 1'b0);
      run_frame(13'd0, 13'd0, 13'd1023, PIX_EXTREME, 1'b0);
      run_frame(13'd2, 13'd2, 13'd0, PIX_EXTREME, 1'b0);
      run_frame(13'd3, 13'd1, 13'd512, PIX_EXTREME, 1'b0);
      run_frame(13'd1, 13'd3, 13'd128, PIX_EXTREME, 1'b0);

      // a burst with no idling on either side
      run_frame(13'd8, 13'd4, 13'd200, PIX_RANDOM, 1'b1);

      random_pixels = 0;
      while (random_pixels < 40) begin
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 4);
         run_frame(CSR_DATA_BITS'(w), CSR_DATA_BITS'(h),
                   CSR_DATA_BITS'($urandom_range(0, 1023)), PIX_RANDOM,
                   $urandom_range(7) == 0);
         random_pixels += w * h;
      end

      wait_idle();
      if (board.pending() != 0)
         $error("%0d expected results never arrived", board.pending());
      if (board.errors == 0 && board.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("status: fail");
      $finish;
   end

endmodule

FILE: luma_laplacian_sharpen_stream_unit.f
+incdir+sv
sv/lls_pkg.sv
sv/lls_ram.sv
sv/lls_queue.sv
sv/lls_front.sv
sv/lls_back.sv
sv/luma_laplacian_sharpen_stream_unit.sv
verif/tb_luma_laplacian_sharpen_stream_unit.sv
